// ===== src/erds_pkg.sv =====
package erds_pkg;

  localparam int TimeFracBits = 16;
  localparam int RateFracBits = 16;
  localparam int TimeW        = 24;
  localparam int TimerW       = TimeW + 2;
  localparam int RateW        = 32;
  localparam int CountW       = 16;
  localparam int ProdW        = RateW + TimeW;
  localparam int SumW         = ProdW + 1;
  localparam int WholeLsb     = RateFracBits + TimeFracBits;
  localparam int WholeW       = SumW - WholeLsb;
  localparam int CfgIndexW    = 3;
  localparam int CfgDataW     = RateW;

  localparam logic [RateW-1:0]  RateReset = RateW'(655360);
  localparam logic [CountW-1:0] CountMax  = '1;

  typedef enum logic [CfgIndexW-1:0] {
    RegEmissionRate = 3'd0,
    RegForceBurst   = 3'd1,
    RegStartEnabled = 3'd2,
    RegDurationOn   = 3'd3,
    RegRunDuration  = 3'd4,
    RegRepeatOn     = 3'd5,
    RegRepeatPause  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic [RateW-1:0] emission_rate;
    logic             force_burst;
    logic             start_enabled;
    logic             duration_on;
    logic [TimeW-1:0] run_duration;
    logic             repeat_on;
    logic [TimeW-1:0] repeat_pause;
  } cfg_t;

  typedef struct packed {
    logic             cmd;
    logic [TimeW-1:0] elapsed;
  } req_t;

  typedef struct packed {
    logic [CountW-1:0] particle_count;
    logic              emitting;
    logic              finished;
  } rsp_t;

endpackage

// ===== src/emission_rate_duty_scheduler.sv =====
// Channel   Payload  Handshake            Direction
// req       req_t    req_valid/req_stall  into block
// rsp       rsp_t    rsp_valid/rsp_stall  out of block
// cfg       cfg_*    cfg_we               into block, write only
//
// One item per cycle sustained while rsp is not stalled.
// An item is held in the input register, then one pass through the multiply-add and
// timer logic updates the emitter state and loads the result register.
// Synchronous reset clears the handshake state and resets the emitter and config registers.
// A stalled result holds the input register; req_stall rises only when both are full
// and rsp is stalled.
module emission_rate_duty_scheduler
  import erds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t cfg;
  logic hold_valid;
  req_t hold_item;
  logic out_free;
  logic step;
  rsp_t result;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign step      = hold_valid && out_free;
  assign req_stall = hold_valid && !out_free;

  erds_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  erds_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (hold_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (!req_stall) begin
        hold_valid <= req_valid;
      end
      if (out_free) begin
        rsp_valid <= hold_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      hold_item <= req;
    end
    if (step) begin
      rsp <= result;
    end
  end

endmodule

// ===== src/erds_cfg.sv =====
module erds_cfg
  import erds_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.emission_rate <= RateReset;
      cfg.force_burst   <= 1'b0;
      cfg.start_enabled <= 1'b1;
      cfg.duration_on   <= 1'b0;
      cfg.run_duration  <= '0;
      cfg.repeat_on     <= 1'b0;
      cfg.repeat_pause  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        RegEmissionRate: cfg.emission_rate <= cfg_data[RateW-1:0];
        RegForceBurst:   cfg.force_burst   <= cfg_data[0];
        RegStartEnabled: cfg.start_enabled <= cfg_data[0];
        RegDurationOn:   cfg.duration_on   <= cfg_data[0];
        RegRunDuration:  cfg.run_duration  <= cfg_data[TimeW-1:0];
        RegRepeatOn:     cfg.repeat_on     <= cfg_data[0];
        RegRepeatPause:  cfg.repeat_pause  <= cfg_data[TimeW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/erds_core.sv =====
module erds_core
  import erds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t item,
  input  cfg_t cfg,
  output rsp_t result
);

  logic              running;
  logic              running_next;
  logic              burst_done;
  logic              burst_done_next;
  logic [15:0]       rate_fraction;
  logic [15:0]       rate_fraction_next;
  logic [TimerW-1:0] run_left;
  logic [TimerW-1:0] run_left_next;
  logic [TimerW-1:0] pause_left;
  logic [TimerW-1:0] pause_left_next;

  logic [ProdW-1:0]  prod;
  logic [SumW-1:0]   sum;
  logic [WholeW-1:0] whole;
  logic [CountW-1:0] timed_count;
  logic [CountW-1:0] count;
  logic [TimerW-1:0] dt;
  logic [TimerW-1:0] run_dec;
  logic [TimerW-1:0] pause_dec;

  assign prod  = ProdW'(cfg.emission_rate) * ProdW'(item.elapsed);
  assign sum   = SumW'(prod) + (SumW'(rate_fraction) << TimeFracBits);
  assign whole = sum[SumW-1:WholeLsb];
  assign timed_count = (|whole[WholeW-1:CountW]) ? CountMax : whole[CountW-1:0];

  assign dt        = TimerW'(item.elapsed);
  assign run_dec   = (run_left > dt) ? run_left - dt : '0;
  assign pause_dec = (pause_left > dt) ? pause_left - dt : '0;

  always_comb begin
    running_next       = running;
    burst_done_next    = burst_done;
    rate_fraction_next = rate_fraction;
    run_left_next      = run_left;
    pause_left_next    = pause_left;
    count              = '0;
    if (item.cmd) begin
      burst_done_next    = 1'b0;
      rate_fraction_next = '0;
      run_left_next      = '0;
      pause_left_next    = '0;
      running_next       = cfg.start_enabled;
      if (cfg.start_enabled && cfg.duration_on) begin
        run_left_next = TimerW'(cfg.run_duration);
      end
      if (!cfg.start_enabled && cfg.repeat_on) begin
        pause_left_next = TimerW'(cfg.repeat_pause);
      end
    end else if (running) begin
      if (!cfg.force_burst) begin
        count              = timed_count;
        rate_fraction_next = sum[TimeFracBits+15:TimeFracBits];
      end else if (!burst_done) begin
        count           = cfg.emission_rate[RateW-1:RateFracBits];
        burst_done_next = 1'b1;
      end
      if (cfg.duration_on) begin
        run_left_next = run_dec;
        if (run_dec == '0) begin
          running_next = 1'b0;
          if (cfg.repeat_on) begin
            pause_left_next = TimerW'(cfg.repeat_pause);
          end
        end
      end
    end else if (cfg.repeat_on) begin
      pause_left_next = pause_dec;
      if (pause_dec == '0) begin
        running_next = 1'b1;
        if (cfg.duration_on) begin
          run_left_next = TimerW'(cfg.run_duration);
        end
      end
    end
  end

  always_comb begin
    result.particle_count = count;
    result.emitting       = running_next;
    result.finished       = !running_next && !cfg.repeat_on;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running       <= 1'b1;
      burst_done    <= 1'b0;
      rate_fraction <= '0;
      run_left      <= '0;
      pause_left    <= '0;
    end else if (step) begin
      running       <= running_next;
      burst_done    <= burst_done_next;
      rate_fraction <= rate_fraction_next;
      run_left      <= run_left_next;
      pause_left    <= pause_left_next;
    end
  end

endmodule
